[rtl/core/nested_region_profiler_assert.svh]
// Assertion macros used by the nested region profiler sequencer.
`ifndef NESTED_REGION_PROFILER_ASSERT_SVH
`define NESTED_REGION_PROFILER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define NRP_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
    else $error("nrp: assertion failed");

// Check that a condition is followed in the next cycle by a consequence.
`define NRP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
    else $error("nrp: sequencing assertion failed");

`endif

[rtl/core/nrp_pkg.sv]
// Package: types, codes and defaults of the nested region profiler.
package nrp_pkg;

    // Default sizes
    localparam int NRP_NUM_REGIONS = 128;
    localparam int NRP_STACK_DEPTH = 128;

    // Event actions
    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_BYTES = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_ID = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Row update kinds
    localparam logic [2:0] UPD_NONE   = 3'd0;
    localparam logic [2:0] UPD_PARENT = 3'd1;
    localparam logic [2:0] UPD_BEGIN  = 3'd2;
    localparam logic [2:0] UPD_END    = 3'd3;
    localparam logic [2:0] UPD_RESUME = 3'd4;
    localparam logic [2:0] UPD_BYTES  = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  region_id;
        logic [63:0] timestamp;
        logic [31:0] byte_count;
    } nrp_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] hit_count;
        logic [63:0] exclusive_time;
        logic [63:0] inclusive_time;
        logic [63:0] byte_total;
        logic [7:0]  open_depth;
    } nrp_out_t;

    // One row of the region table
    typedef struct packed {
        logic [63:0] resume;
        logic [63:0] hits;
        logic [63:0] excl;
        logic [63:0] incl;
        logic [63:0] byte_sum;
    } nrp_row_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       item_ld;
        logic       stk_rd;
        logic       top_ld;
        logic       row_rd;
        logic       row_top;
        logic       row_lat;
        logic       row_wr;
        logic [2:0] upd;
        logic       push;
        logic       pop;
        logic       res_ld;
        logic       res_err;
        logic [1:0] err_code;
        logic       out_ld;
    } nrp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] action;
        logic       id_bad;
        logic       cnt_zero;
        logic       cnt_one;
        logic       cnt_full;
    } nrp_stat_t;

endpackage

[rtl/core/nested_region_profiler.sv]
// A rejected event goes from decode straight to the result. Add bytes, an end and a nested
// begin first read the stack top; a nested begin updates the parent row before its own, and
// an end that resumes a parent reads the stack again and updates that row. Each row touched
// is read, latched and written (a read writes nothing); a stalled result holds the next.
// Reset (aresetn low, synchronous) empties the stack and marks every region row as
// zero through per-row valid bits; no clearing pass is needed.
module nested_region_profiler
    import nrp_pkg::*;
#(
    parameter int NUM_REGIONS = NRP_NUM_REGIONS,
    parameter int STACK_DEPTH = NRP_STACK_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  nrp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output nrp_out_t m_data
);

    nrp_cmd_t  cmd;
    nrp_stat_t st;

    // Sequencer
    nrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // Stack, region table and result registers
    nrp_datapath #(
        .NUM_REGIONS (NUM_REGIONS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

[rtl/core/nrp_ram.sv]
// Generic simple dual-port RAM with registered read.
module nrp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, read one word into the output register
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/nrp_ctrl.sv]
// Sequencer of the nested region profiler: event decode and table access order.
`include "nested_region_profiler_assert.svh"

module nrp_ctrl
    import nrp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  nrp_stat_t st,
    output nrp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_STK_RD   = 3'd2;
    localparam logic [2:0] S_STK_WAIT = 3'd3;
    localparam logic [2:0] S_ROW_RD   = 3'd4;
    localparam logic [2:0] S_ROW_LAT  = 3'd5;
    localparam logic [2:0] S_ROW_WR   = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] pass_reg, pass_next;
    logic       m_valid_reg, m_valid_next;

    // Sequence one transaction through stack and table accesses
    always_comb begin
        cmd          = '0;
        cmd.upd      = pass_reg;
        cmd.row_top  = (pass_reg != UPD_BEGIN) && (pass_reg != UPD_NONE);
        state_next   = state_reg;
        pass_next    = pass_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.item_ld = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (st.action) inside
                    ACT_BEGIN: begin
                        if (st.id_bad) begin
                            cmd.res_err  = 1'b1;
                            cmd.err_code = ST_BAD_ID;
                            state_next   = S_RESP;
                        end else if (st.cnt_full) begin
                            cmd.res_err  = 1'b1;
                            cmd.err_code = ST_FULL;
                            state_next   = S_RESP;
                        end else if (st.cnt_zero) begin
                            pass_next  = UPD_BEGIN;
                            state_next = S_ROW_RD;
                        end else begin
                            pass_next  = UPD_PARENT;
                            state_next = S_STK_RD;
                        end
                    end
                    ACT_END, ACT_BYTES: begin
                        if (st.cnt_zero) begin
                            cmd.res_err  = 1'b1;
                            cmd.err_code = ST_EMPTY;
                            state_next   = S_RESP;
                        end else begin
                            pass_next  = (st.action == ACT_END) ? UPD_END : UPD_BYTES;
                            state_next = S_STK_RD;
                        end
                    end
                    ACT_READ: begin
                        if (st.id_bad) begin
                            cmd.res_err  = 1'b1;
                            cmd.err_code = ST_BAD_ID;
                            state_next   = S_RESP;
                        end else begin
                            pass_next  = UPD_NONE;
                            state_next = S_ROW_RD;
                        end
                    end
                endcase
            end
            S_STK_RD: begin
                cmd.stk_rd = 1'b1;
                state_next = S_STK_WAIT;
            end
            S_STK_WAIT: begin
                cmd.top_ld = 1'b1;
                state_next = S_ROW_RD;
            end
            S_ROW_RD: begin
                cmd.row_rd = 1'b1;
                state_next = S_ROW_LAT;
            end
            S_ROW_LAT: begin
                cmd.row_lat = 1'b1;
                state_next  = S_ROW_WR;
            end
            S_ROW_WR: begin
                cmd.row_wr = (pass_reg != UPD_NONE);
                unique case (pass_reg) inside
                    UPD_PARENT: begin
                        pass_next  = UPD_BEGIN;
                        state_next = S_ROW_RD;
                    end
                    UPD_BEGIN: begin
                        cmd.push   = 1'b1;
                        cmd.res_ld = 1'b1;
                        state_next = S_RESP;
                    end
                    UPD_END: begin
                        cmd.pop    = 1'b1;
                        cmd.res_ld = 1'b1;
                        if (st.cnt_one) begin
                            state_next = S_RESP;
                        end else begin
                            pass_next  = UPD_RESUME;
                            state_next = S_STK_RD;
                        end
                    end
                    UPD_BYTES, UPD_NONE: begin
                        cmd.res_ld = 1'b1;
                        state_next = S_RESP;
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_ld   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pass_reg    <= UPD_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `NRP_ASSERT(a_push_not_full, cmd.push |-> !st.cnt_full)
    `NRP_ASSERT(a_pop_not_empty, cmd.pop |-> !st.cnt_zero)
    `NRP_ASSERT(a_stk_rd_not_empty, cmd.stk_rd |-> !st.cnt_zero)
    `NRP_ASSERT(a_no_result_overwrite, cmd.out_ld |-> (!m_valid_reg || m_ready))
    `NRP_ASSERT_NEXT(a_write_after_latch, cmd.row_lat, state_reg == S_ROW_WR)

endmodule

[rtl/core/nrp_datapath.sv]
// Datapath of the nested region profiler: region table, region stack and result registers.
module nrp_datapath
    import nrp_pkg::*;
#(
    parameter int NUM_REGIONS = NRP_NUM_REGIONS,
    parameter int STACK_DEPTH = NRP_STACK_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  nrp_in_t   s_data,
    output nrp_out_t  m_data,
    input  nrp_cmd_t  cmd,
    output nrp_stat_t st
);

    localparam int IDW = $clog2(NUM_REGIONS);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int RW  = $bits(nrp_row_t);
    localparam int EW  = IDW + 64;
    localparam logic [8:0]    NUM_REGIONS_W = 9'(NUM_REGIONS);
    localparam logic [CW-1:0] DEPTH_W       = CW'(STACK_DEPTH);

    nrp_in_t           item_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_m1;
    logic [CW+7:0]     count_ext;
    logic [IDW-1:0]    top_id_reg;
    logic [63:0]       top_begin_reg;
    logic [IDW-1:0]    row_addr;
    logic [IDW-1:0]    row_addr_reg;
    logic              rd_valid_reg;
    logic [NUM_REGIONS-1:0] row_valid_reg;
    nrp_row_t          row_rd_data;
    nrp_row_t          row_eff;
    nrp_row_t          row_reg;
    nrp_row_t          new_row;
    logic [63:0]       dt_excl_reg;
    logic [63:0]       dt_incl_reg;
    nrp_row_t          res_row_reg;
    logic [1:0]        res_status_reg;
    nrp_out_t          out_reg;
    logic [EW-1:0]     stk_wr_data;
    logic [EW-1:0]     stk_rd_data;
    logic [RW-1:0]     row_ram_rd;

    // Status towards the controller
    assign count_m1    = count_reg - CW'(1);
    assign st.action   = item_reg.action;
    assign st.id_bad   = {1'b0, item_reg.region_id} >= NUM_REGIONS_W;
    assign st.cnt_zero = (count_reg == '0);
    assign st.cnt_one  = (count_reg == CW'(1));
    assign st.cnt_full = (count_reg == DEPTH_W);

    // Stack of open regions: id and begin time per entry
    assign stk_wr_data = {item_reg.region_id[IDW-1:0], item_reg.timestamp};

    nrp_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (count_reg[SAW-1:0]),
        .wr_data (stk_wr_data),
        .rd_en   (cmd.stk_rd),
        .rd_addr (count_m1[SAW-1:0]),
        .rd_data (stk_rd_data)
    );

    // Region table, one row per region
    assign row_addr = cmd.row_top ? top_id_reg : item_reg.region_id[IDW-1:0];

    nrp_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_REGIONS)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (cmd.row_wr),
        .wr_addr (row_addr_reg),
        .wr_data (new_row),
        .rd_en   (cmd.row_rd),
        .rd_addr (row_addr),
        .rd_data (row_ram_rd)
    );

    // Rows never written since reset read as zero
    assign row_rd_data = row_ram_rd;
    assign row_eff     = rd_valid_reg ? row_rd_data : '0;

    // Apply one update to the latched row
    always_comb begin
        new_row = row_reg;
        unique case (cmd.upd)
            UPD_PARENT: new_row.excl = row_reg.excl + dt_excl_reg;
            UPD_BEGIN: begin
                new_row.resume = item_reg.timestamp;
                new_row.hits   = row_reg.hits + 64'd1;
            end
            UPD_END: begin
                new_row.excl = row_reg.excl + dt_excl_reg;
                new_row.incl = row_reg.incl + dt_incl_reg;
            end
            UPD_RESUME: new_row.resume = item_reg.timestamp;
            UPD_BYTES:  new_row.byte_sum = row_reg.byte_sum + {32'd0, item_reg.byte_count};
            default:    new_row = row_reg;
        endcase
    end

    // Control state: stack count and row valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            row_valid_reg <= '0;
        end else begin
            if (cmd.push) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.pop) begin
                count_reg <= count_m1;
            end
            if (cmd.row_wr) begin
                row_valid_reg[row_addr_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.item_ld) begin
            item_reg <= s_data;
        end
        if (cmd.top_ld) begin
            top_id_reg    <= stk_rd_data[EW-1:64];
            top_begin_reg <= stk_rd_data[63:0];
        end
        if (cmd.row_rd) begin
            row_addr_reg <= row_addr;
            rd_valid_reg <= row_valid_reg[row_addr];
        end
        if (cmd.row_lat) begin
            row_reg     <= row_eff;
            dt_excl_reg <= item_reg.timestamp - row_eff.resume;
            dt_incl_reg <= item_reg.timestamp - top_begin_reg;
        end
        if (cmd.res_err) begin
            res_status_reg <= cmd.err_code;
            res_row_reg    <= '0;
        end else if (cmd.res_ld) begin
            res_status_reg <= ST_OK;
            res_row_reg    <= new_row;
        end
        if (cmd.out_ld) begin
            out_reg.status         <= res_status_reg;
            out_reg.hit_count      <= res_row_reg.hits;
            out_reg.exclusive_time <= res_row_reg.excl;
            out_reg.inclusive_time <= res_row_reg.incl;
            out_reg.byte_total     <= res_row_reg.byte_sum;
            out_reg.open_depth     <= count_ext[7:0];
        end
    end

    assign count_ext = {8'd0, count_reg};
    assign m_data    = out_reg;

endmodule
